### design/gcts_pkg.sv
// Shared types, constants and helpers for the grid cut-time search block.
// Used by gcts_probe and grid_cut_time_search; depends on nothing.
package gcts_pkg;

  localparam int unsigned DEF_MAX_ROWS   = 256;
  localparam int unsigned DEF_MAX_COLS   = 256;
  localparam int unsigned DEF_MAX_EVENTS = 65535;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_WALL  = 2'd1;
  localparam logic [1:0] CMD_BLOCK = 2'd2;
  localparam logic [1:0] CMD_RUN   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  localparam logic [8:0] DIM_RESET = 9'd256;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] row;
    logic [7:0] col;
    logic       wall;
  } item_t;

  typedef struct packed {
    logic [15:0] cut_time;
    logic        never_cut;
  } result_t;

  typedef struct packed {
    logic       go;
    logic [8:0] rows;
    logic [8:0] cols;
  } probe_ctl_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic joined;
  } probe_sts_t;

  // zero reads as one, anything above the maximum saturates
  function automatic logic [8:0] clamp_dim(logic [8:0] v, int unsigned maxv);
    logic [8:0] r;
    if (v == 9'd0) r = 9'd1;
    else if (32'(v) > maxv) r = 9'(maxv);
    else r = v;
    return r;
  endfunction

endpackage

### design/grid_cut_time_search.sv
// Top level of the grid cut-time search: command decode, wall and stamp stores,
// binary search over event counts. Uses gcts_pkg, gcts_ram, gcts_probe.
//
// Usage: a command beat is taken when start is high and busy is low.
//   Wall write and block event complete at the accepting edge; busy stays low.
//   Clear events sweeps the stamp store, one cell a cycle, over all
//   2^(RW+CW) cells (65536 at defaults), with busy high.
//   Run search probes about log2(events)+1 event counts. Each probe is a flood
//   fill: it checks each top-row column, then each reached cell's neighbours,
//   then clears the visited map one reached cell a cycle. The single result
//   beat appears on result with done high for exactly one cycle; busy is
//   already low in that cycle. The receiver cannot stall; the beat is gone
//   after that cycle.
// Configuration: cfg_valid/cfg_ready write grid_rows (index 0) or grid_cols
//   (index 1); cfg_ready is always high. Write only while busy is low.
// Reset: rst is synchronous; afterwards the block runs the same clearing
//   sweep over stamps and visited map with busy high.
//   Wall cells are undefined until written.
module grid_cut_time_search #(
  parameter int unsigned MAX_ROWS   = gcts_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS   = gcts_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_EVENTS = gcts_pkg::DEF_MAX_EVENTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gcts_pkg::item_t   item,
  output logic              done,
  output gcts_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW = RW + CW;
  localparam int unsigned EW = $clog2(MAX_EVENTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  logic [1:0]    state;
  logic [8:0]    grid_rows, grid_cols;
  logic [EW-1:0] ev_cnt, low, high, tim;
  logic [EW:0]   mid_sum;
  logic [AW-1:0] sweep_addr, cell_in, probe_raddr;
  logic          is_final, go, accept, in_store, ev_full;
  logic          wall_rd;
  logic [EW-1:0] stamp_rd;
  logic          stamp_we;
  logic [AW-1:0] stamp_waddr;
  logic [EW-1:0] stamp_wdata;
  logic [31:0]   low_ext;
  gcts_pkg::probe_ctl_t pctl;
  gcts_pkg::probe_sts_t psts;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_store  = (32'(item.row) < MAX_ROWS) && (32'(item.col) < MAX_COLS);
  assign cell_in   = {RW'(item.row), CW'(item.col)};
  assign ev_full   = (ev_cnt == EW'(MAX_EVENTS));
  assign mid_sum   = {1'b0, low} + {1'b0, high};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= gcts_pkg::clamp_dim(gcts_pkg::DIM_RESET, MAX_ROWS);
      grid_cols <= gcts_pkg::clamp_dim(gcts_pkg::DIM_RESET, MAX_COLS);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == gcts_pkg::REG_ROWS)
        grid_rows <= gcts_pkg::clamp_dim(cfg_data, MAX_ROWS);
      else if (cfg_index == gcts_pkg::REG_COLS)
        grid_cols <= gcts_pkg::clamp_dim(cfg_data, MAX_COLS);
    end
  end

  // stamp store write: clearing sweep or block event
  always_comb begin
    stamp_we    = 1'b0;
    stamp_waddr = cell_in;
    stamp_wdata = ev_cnt + EW'(1);
    if (state == ST_SWEEP) begin
      stamp_we    = 1'b1;
      stamp_waddr = sweep_addr;
      stamp_wdata = '0;
    end else if (accept && item.cmd == gcts_pkg::CMD_BLOCK) begin
      stamp_we = !ev_full && in_store;
    end
  end

  gcts_ram #(.WIDTH(1), .DEPTH(2**AW)) u_wall (
    .clk(clk), .we(accept && item.cmd == gcts_pkg::CMD_WALL && in_store),
    .waddr(cell_in), .wdata(item.wall), .raddr(probe_raddr), .rdata(wall_rd)
  );

  gcts_ram #(.WIDTH(EW), .DEPTH(2**AW)) u_stamp (
    .clk(clk), .we(stamp_we), .waddr(stamp_waddr), .wdata(stamp_wdata),
    .raddr(probe_raddr), .rdata(stamp_rd)
  );

  assign pctl.go   = go;
  assign pctl.rows = grid_rows;
  assign pctl.cols = grid_cols;

  gcts_probe #(.RW(RW), .CW(CW), .EW(EW)) u_probe (
    .clk(clk), .rst(rst), .ctl(pctl), .tim(tim), .cell_raddr(probe_raddr),
    .wall_rd(wall_rd), .stamp_rd(stamp_rd), .sts(psts)
  );

  assign low_ext = 32'(low);

  // command decode and binary search
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      ev_cnt     <= '0;
      low        <= '0;
      high       <= '0;
      go         <= 1'b0;
      done       <= 1'b0;
    end else begin
      go   <= 1'b0;
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (item.cmd)
              gcts_pkg::CMD_CLEAR: begin
                ev_cnt     <= '0;
                sweep_addr <= '0;
                state      <= ST_SWEEP;
              end
              gcts_pkg::CMD_BLOCK: begin
                if (!ev_full) ev_cnt <= ev_cnt + EW'(1);
              end
              gcts_pkg::CMD_RUN: begin
                low   <= '0;
                high  <= ev_cnt;
                state <= ST_STEP;
              end
              default: ;
            endcase
          end
        end
        ST_SWEEP: begin
          if (!(&sweep_addr)) sweep_addr <= sweep_addr + AW'(1);
          else if (psts.ready) state <= ST_IDLE;
        end
        ST_STEP: begin
          is_final <= (low == high);
          tim      <= (low == high) ? low : mid_sum[EW:1];
          go       <= 1'b1;
          state    <= ST_WAIT;
        end
        ST_WAIT: begin
          if (psts.done) begin
            if (is_final) begin
              done             <= 1'b1;
              result.never_cut <= psts.joined;
              result.cut_time  <= psts.joined ? 16'd0 : low_ext[15:0];
              state            <= ST_IDLE;
            end else begin
              if (psts.joined) low <= tim + EW'(1);
              else high <= tim;
              state <= ST_STEP;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a result beat only ends a search
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_WAIT)
    else $error("result beat outside a search");

  // never-cut results carry a zero cut time
  assert property (@(posedge clk) disable iff (rst)
    done && result.never_cut |-> result.cut_time == 16'd0)
    else $error("never_cut with non-zero cut_time");

  // search bounds stay ordered
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP || state == ST_WAIT) |-> low <= high)
    else $error("search bounds crossed");

  // probe is only started when it is idle
  assert property (@(posedge clk) disable iff (rst)
    go |-> psts.ready)
    else $error("probe started while busy");

endmodule

### design/gcts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gcts_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### design/gcts_probe.sv
// Flood-fill probe: tests whether the top row still reaches the bottom row at a
// given event count. Holds the visited map and cell queue. Uses gcts_pkg, gcts_ram.
module gcts_probe #(
  parameter int unsigned RW = 8,
  parameter int unsigned CW = 8,
  parameter int unsigned EW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gcts_pkg::probe_ctl_t  ctl,
  input  logic [EW-1:0]         tim,
  output logic [RW+CW-1:0]      cell_raddr,
  input  logic                  wall_rd,
  input  logic [EW-1:0]         stamp_rd,
  output gcts_pkg::probe_sts_t  sts
);

  localparam int unsigned AW = RW + CW;

  localparam logic [3:0] PR_INIT     = 4'd0;
  localparam logic [3:0] PR_IDLE     = 4'd1;
  localparam logic [3:0] PR_SEED_RD  = 4'd2;
  localparam logic [3:0] PR_SEED_CHK = 4'd3;
  localparam logic [3:0] PR_QRD      = 4'd4;
  localparam logic [3:0] PR_QCAP     = 4'd5;
  localparam logic [3:0] PR_NB       = 4'd6;
  localparam logic [3:0] PR_NCHK     = 4'd7;
  localparam logic [3:0] PR_CLR      = 4'd8;
  localparam logic [3:0] PR_DONE     = 4'd9;

  logic [3:0]    st;
  logic [AW-1:0] cand, cand_next, init_addr;
  logic [CW-1:0] seed_c, cur_c;
  logic [RW-1:0] cur_r;
  logic [1:0]    dir;
  logic [AW:0]   head, tail, clr_idx;
  logic          pend, joined;
  logic          nb_ok, vis_rd, closed, open_cell, is_bottom, checking;
  logic          vis_we, vis_wdata;
  logic [AW-1:0] vis_waddr, q_raddr, q_rdata;

  // neighbour address and bounds for the current direction
  always_comb begin
    cand_next = cand;
    nb_ok     = 1'b0;
    if (st == PR_SEED_RD) begin
      cand_next = {RW'(0), seed_c};
    end else if (st == PR_NB) begin
      case (dir)
        2'd0: begin
          nb_ok     = (cur_r != '0);
          cand_next = {cur_r - RW'(1), cur_c};
        end
        2'd1: begin
          nb_ok     = (32'(cur_c) + 32'd1 < 32'(ctl.cols));
          cand_next = {cur_r, cur_c + CW'(1)};
        end
        2'd2: begin
          nb_ok     = (32'(cur_r) + 32'd1 < 32'(ctl.rows));
          cand_next = {cur_r + RW'(1), cur_c};
        end
        default: begin
          nb_ok     = (cur_c != '0);
          cand_next = {cur_r, cur_c - CW'(1)};
        end
      endcase
    end
  end

  assign cell_raddr = cand_next;

  // cell test on the data read last cycle
  assign closed    = wall_rd || (stamp_rd != '0 && stamp_rd <= tim);
  assign open_cell = !closed && !vis_rd;
  assign is_bottom = (32'(cand[AW-1:CW]) + 32'd1 == 32'(ctl.rows));
  assign checking  = (st == PR_SEED_CHK) || (st == PR_NCHK);

  // visited map write: reset sweep, marking, or clearing from the queue
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = cand;
    vis_wdata = 1'b0;
    case (st)
      PR_INIT: begin
        vis_we    = 1'b1;
        vis_waddr = init_addr;
      end
      PR_SEED_CHK, PR_NCHK: begin
        vis_we    = open_cell;
        vis_wdata = 1'b1;
      end
      PR_CLR: begin
        vis_we    = pend;
        vis_waddr = q_rdata;
      end
      default: vis_we = 1'b0;
    endcase
  end

  assign q_raddr = (st == PR_CLR) ? clr_idx[AW-1:0] : head[AW-1:0];

  gcts_ram #(.WIDTH(1), .DEPTH(2**AW)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(cand_next), .rdata(vis_rd)
  );

  gcts_ram #(.WIDTH(AW), .DEPTH(2**AW)) u_queue (
    .clk(clk), .we(checking && open_cell), .waddr(tail[AW-1:0]), .wdata(cand),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= PR_INIT;
      init_addr <= '0;
      joined    <= 1'b0;
      pend      <= 1'b0;
    end else begin
      case (st)
        PR_INIT: begin
          init_addr <= init_addr + AW'(1);
          if (&init_addr) st <= PR_IDLE;
        end
        PR_IDLE: begin
          if (ctl.go) begin
            seed_c <= '0;
            head   <= '0;
            tail   <= '0;
            joined <= 1'b0;
            st     <= PR_SEED_RD;
          end
        end
        PR_SEED_RD: begin
          cand <= cand_next;
          st   <= PR_SEED_CHK;
        end
        PR_SEED_CHK: begin
          if (open_cell) begin
            tail <= tail + (AW+1)'(1);
            if (is_bottom) joined <= 1'b1;
          end
          if (32'(seed_c) + 32'd1 == 32'(ctl.cols)) st <= PR_QRD;
          else begin
            seed_c <= seed_c + CW'(1);
            st     <= PR_SEED_RD;
          end
        end
        PR_QRD: begin
          if (joined || head == tail) begin
            clr_idx <= '0;
            pend    <= 1'b0;
            st      <= PR_CLR;
          end else st <= PR_QCAP;
        end
        PR_QCAP: begin
          cur_r <= q_rdata[AW-1:CW];
          cur_c <= q_rdata[CW-1:0];
          head  <= head + (AW+1)'(1);
          dir   <= 2'd0;
          st    <= PR_NB;
        end
        PR_NB: begin
          if (nb_ok) begin
            cand <= cand_next;
            st   <= PR_NCHK;
          end else if (dir == 2'd3) st <= PR_QRD;
          else dir <= dir + 2'd1;
        end
        PR_NCHK: begin
          if (open_cell) begin
            tail <= tail + (AW+1)'(1);
            if (is_bottom) joined <= 1'b1;
          end
          if (dir == 2'd3) st <= PR_QRD;
          else begin
            dir <= dir + 2'd1;
            st  <= PR_NB;
          end
        end
        PR_CLR: begin
          pend <= (clr_idx != tail);
          if (clr_idx != tail) clr_idx <= clr_idx + (AW+1)'(1);
          else if (!pend) st <= PR_DONE;
        end
        PR_DONE: st <= PR_IDLE;
        default: st <= PR_IDLE;
      endcase
    end
  end

  assign sts.ready  = (st == PR_IDLE);
  assign sts.done   = (st == PR_DONE);
  assign sts.joined = joined;

endmodule

### verif/grid_cut_time_search_tb.sv
// Testbench for grid_cut_time_search: drives wall, block-event, clear and run commands,
// predicts each cut time with its own flood-fill search and checks every result beat.
// Depends on gcts_pkg and the grid_cut_time_search RTL.
module grid_cut_time_search_tb;

  localparam int unsigned STALL_LIMIT = 400000;

  // predicts cut times from its own copy of walls, stamps and grid size
  class cut_time_tracker;
    bit          wall_bit[65536];
    bit          known[65536];
    bit [15:0]   stamp[65536];
    bit          seen[65536];
    int unsigned events;
    int unsigned rows = gcts_pkg::DEF_MAX_ROWS;
    int unsigned cols = gcts_pkg::DEF_MAX_COLS;
    gcts_pkg::result_t pending_cuts[$];
    int unsigned errors;

    function int unsigned clamp(logic [8:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return 32'(v);
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] val);
      if (idx == gcts_pkg::REG_ROWS) rows = clamp(val, gcts_pkg::DEF_MAX_ROWS);
      else if (idx == gcts_pkg::REG_COLS) cols = clamp(val, gcts_pkg::DEF_MAX_COLS);
    endfunction

    function bit closed(int unsigned at, int unsigned t);
      return wall_bit[at] || (stamp[at] != 0 && stamp[at] <= t);
    endfunction

    // flood fill from the open top-row cells at event count t
    function bit joined(int unsigned t);
      int unsigned cells[$];
      int unsigned head, at, r, c, nr, nc, nat;
      bit hit;
      for (c = 0; c < cols; c++) begin
        if (!closed(c, t) && !seen[c]) begin
          seen[c] = 1;
          cells = {cells, c};
        end
      end
      head = 0;
      while (head < cells.size()) begin
        at = cells[head];
        head++;
        r = at / 256;
        c = at % 256;
        for (int d = 0; d < 4; d++) begin
          if (d == 0 && r == 0) continue;
          if (d == 3 && c == 0) continue;
          nr = (d == 0) ? r - 1 : (d == 2) ? r + 1 : r;
          nc = (d == 3) ? c - 1 : (d == 1) ? c + 1 : c;
          if (nr >= rows || nc >= cols) continue;
          nat = nr * 256 + nc;
          if (closed(nat, t) || seen[nat]) continue;
          seen[nat] = 1;
          cells = {cells, nat};
        end
      end
      hit = 0;
      for (c = 0; c < cols; c++) if (seen[(rows - 1) * 256 + c]) hit = 1;
      foreach (cells[i]) seen[cells[i]] = 0;
      return hit;
    endfunction

    function void note(gcts_pkg::item_t it);
      int unsigned at;
      int unsigned lo, hi, mid;
      gcts_pkg::result_t res;
      at = 32'({it.row, it.col});
      case (it.cmd)
        gcts_pkg::CMD_CLEAR: begin
          foreach (stamp[i]) stamp[i] = '0;
          events = 0;
        end
        gcts_pkg::CMD_WALL: begin
          wall_bit[at] = it.wall;
          known[at] = 1;
        end
        gcts_pkg::CMD_BLOCK: begin
          if (events < gcts_pkg::DEF_MAX_EVENTS) begin
            events++;
            stamp[at] = events[15:0];
          end
        end
        default: begin
          lo = 0;
          hi = events;
          while (lo != hi) begin
            mid = (lo + hi) >> 1;
            if (joined(mid)) lo = mid + 1;
            else hi = mid;
          end
          if (joined(lo)) begin
            res.cut_time = '0;
            res.never_cut = 1'b1;
          end else begin
            res.cut_time = lo[15:0];
            res.never_cut = 1'b0;
          end
          pending_cuts = {pending_cuts, res};
        end
      endcase
    endfunction

    function void check_cut(gcts_pkg::result_t got);
      gcts_pkg::result_t want;
      if (pending_cuts.size() == 0) begin
        $error("unexpected result beat: cut_time %0d never_cut %0d",
               got.cut_time, got.never_cut);
        errors++;
        return;
      end
      want = pending_cuts.pop_front();
      if (got.cut_time !== want.cut_time) begin
        $error("cut_time: expected %0d, got %0d", want.cut_time, got.cut_time);
        errors++;
      end
      if (got.never_cut !== want.never_cut) begin
        $error("never_cut: expected %0d, got %0d", want.never_cut, got.never_cut);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  gcts_pkg::item_t   item;
  logic              done;
  gcts_pkg::result_t result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [8:0]        cfg_data;

  cut_time_tracker tracker = new();
  bit          calm;
  int unsigned quiet_cycles;
  int unsigned issued;

  grid_cut_time_search dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result beats are taken at the edge that ends their cycle
  always @(posedge clk) begin
    if (!rst && done) tracker.check_cut(result);
  end

  // watchdog on cycles with no beat of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(gcts_pkg::item_t it);
    while (!calm && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    tracker.note(it);
    issued++;
  endtask

  task automatic command(logic [1:0] cmd, logic [7:0] r, logic [7:0] c, logic w);
    gcts_pkg::item_t it;
    it.cmd = cmd;
    it.row = r;
    it.col = c;
    it.wall = w;
    issue(it);
  endtask

  // wait for every outstanding result and for the block to go idle
  task automatic settle();
    start <= 1'b0;
    while (tracker.pending_cuts.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [8:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.write_reg(idx, val);
  endtask

  // new grid size, then fill in every wall cell not yet written inside it
  task automatic shape_grid(logic [8:0] rv, logic [8:0] cv);
    set_reg(gcts_pkg::REG_ROWS, rv);
    set_reg(gcts_pkg::REG_COLS, cv);
    for (int r = 0; r < tracker.rows; r++)
      for (int c = 0; c < tracker.cols; c++)
        if (!tracker.known[r * 256 + c])
          command(gcts_pkg::CMD_WALL, 8'(r), 8'(c), $urandom_range(3) == 0);
  endtask

  initial begin
    logic [7:0]  r, c;
    int unsigned pick, lim_r, lim_c;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    issued = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // single-row grid; zero rows reads as one
    shape_grid(9'd0, 9'd4);
    for (int i = 0; i < 4; i++) command(gcts_pkg::CMD_WALL, 8'd0, 8'(i), 1'b0);
    command(gcts_pkg::CMD_RUN, 8'd0, 8'd0, 1'b0);
    for (int i = 0; i < 4; i++) command(gcts_pkg::CMD_BLOCK, 8'd0, 8'(i), 1'b0);
    command(gcts_pkg::CMD_RUN, 8'd0, 8'd0, 1'b0);
    command(gcts_pkg::CMD_BLOCK, 8'd0, 8'd1, 1'b0);
    command(gcts_pkg::CMD_BLOCK, 8'd255, 8'd255, 1'b0);
    command(gcts_pkg::CMD_WALL, 8'd255, 8'd255, 1'b1);
    command(gcts_pkg::CMD_RUN, 8'd0, 8'd0, 1'b0);
    command(gcts_pkg::CMD_WALL, 8'd0, 8'd2, 1'b1);
    command(gcts_pkg::CMD_RUN, 8'd0, 8'd0, 1'b0);
    command(gcts_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0);
    command(gcts_pkg::CMD_RUN, 8'd0, 8'd0, 1'b0);
    set_reg(2'd3, 9'd511);

    // tallest column, then widest row (oversize saturates)
    shape_grid(9'd256, 9'd1);
    for (int i = 0; i < 256; i++) command(gcts_pkg::CMD_WALL, 8'(i), 8'd0, 1'b0);
    command(gcts_pkg::CMD_RUN, 8'd0, 8'd0, 1'b0);
    command(gcts_pkg::CMD_BLOCK, 8'd128, 8'd0, 1'b0);
    command(gcts_pkg::CMD_BLOCK, 8'd255, 8'd0, 1'b0);
    command(gcts_pkg::CMD_RUN, 8'd0, 8'd0, 1'b0);
    shape_grid(9'd1, 9'd511);
    command(gcts_pkg::CMD_RUN, 8'd0, 8'd0, 1'b0);

    // wall across the middle: cut before any event
    shape_grid(9'd5, 9'd5);
    for (int i = 0; i < 5; i++) command(gcts_pkg::CMD_WALL, 8'd2, 8'(i), 1'b1);
    command(gcts_pkg::CMD_RUN, 8'd0, 8'd0, 1'b0);
    command(gcts_pkg::CMD_WALL, 8'd2, 8'd3, 1'b0);
    command(gcts_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0);

    // burst of block events with no idling
    shape_grid(9'd3, 9'd3);
    calm = 1'b1;
    for (int i = 0; i < 60; i++)
      command(gcts_pkg::CMD_BLOCK, 8'($urandom_range(3)), 8'($urandom_range(3)), 1'b0);
    command(gcts_pkg::CMD_RUN, 8'd0, 8'd0, 1'b0);
    calm = 1'b0;
    command(gcts_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0);

    // random phases on mostly small grids
    for (int ph = 0; issued < 1150; ph++) begin
      lim_r = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      lim_c = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      shape_grid(9'(lim_r), 9'(lim_c));
      issued = 0 + issued;
      calm = (ph == 3);
      for (int k = 0; k < 100; k++) begin
        if (ph == 5 && k == 50) settle();
        if ($urandom_range(6) == 0) begin
          r = 8'($urandom);
          c = 8'($urandom);
        end else begin
          r = 8'($urandom_range(tracker.rows - 1));
          c = 8'($urandom_range(tracker.cols - 1));
        end
        pick = $urandom_range(999);
        if (pick < 5) command(gcts_pkg::CMD_CLEAR, r, c, 1'($urandom));
        else if (pick < 185) command(gcts_pkg::CMD_RUN, r, c, 1'($urandom));
        else if (pick < 480) command(gcts_pkg::CMD_WALL, r, c, $urandom_range(2) == 0);
        else command(gcts_pkg::CMD_BLOCK, r, c, 1'($urandom));
      end
    end
    calm = 1'b0;

    settle();
    repeat (64) @(posedge clk);
    tracker.errors += tracker.pending_cuts.size();
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
